@@ design/gf163_pkg.sv @@
// ----------------------------------------------------------------------------
// gf163_pkg
// Types, sizes and arithmetic helpers for GF(2^163) multiplication in
// polynomial basis, p(x) = x^163 + x^8 + x^2 + x + 1.
// ----------------------------------------------------------------------------
package gf163_pkg;

    localparam int ELEM_W = 163;
    localparam int PROD_W = 2 * ELEM_W - 1;
    localparam int WORD_W = 64;
    localparam int TOP_W  = ELEM_W - 2 * WORD_W;

    typedef logic [ELEM_W-1:0] t_elem;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [TOP_W-1:0]  t_top;

    // carry-less product, one XOR tree per product bit
    function automatic t_prod clmul(t_elem a, t_elem b);
        t_prod p;
        t_elem t;
        int    k;
        int    i;
        p = '0;
        for (k = 0; k < PROD_W; k++) begin
            for (i = 0; i < ELEM_W; i++) begin
                if ((k - i >= 0) && (k - i < ELEM_W)) begin
                    t[i] = a[i] & b[k-i];
                end else begin
                    t[i] = 1'b0;
                end
            end
            p[k] = ^t;
        end
        return p;
    endfunction

    // x^163 == x^8 + x^2 + x + 1; two folds bring 325 bits down to 163
    function automatic t_elem reduce(t_prod p);
        logic [161:0] h;
        logic [170:0] r;
        logic [7:0]   h2;
        t_elem        q;
        h  = p[324:163];
        r  = {8'b0, p[162:0]} ^ {9'b0, h} ^ {8'b0, h, 1'b0}
           ^ {7'b0, h, 2'b0} ^ {1'b0, h, 8'b0};
        h2 = r[170:163];
        q  = r[162:0] ^ {155'b0, h2} ^ {154'b0, h2, 1'b0}
           ^ {153'b0, h2, 2'b0} ^ {147'b0, h2, 8'b0};
        return q;
    endfunction

endpackage

@@ design/gf163_mul_core.sv @@
// ----------------------------------------------------------------------------
// gf163_mul_core
// Combinational GF(2^163) multiply: carry-less product and pentanomial fold.
// ----------------------------------------------------------------------------
module gf163_mul_core
    import gf163_pkg::*;
(
    input  t_elem i_a,
    input  t_elem i_b,
    output t_elem o_prod
);

    t_prod w_full;

    assign w_full = clmul(i_a, i_b);
    assign o_prod = reduce(w_full);

endmodule

@@ design/gf2_163_field_multiplier.sv @@
// ----------------------------------------------------------------------------
// gf2_163_field_multiplier
// GF(2^163) polynomial-basis multiplier with valid/stall word channels.
// ----------------------------------------------------------------------------
// Path: from input acceptance to output valid, data passes the operand register,
//   then the product register.
// Throughput: one operand pair per cycle while o_stall is low; the
//   multiply-and-fold between the two registers is a single pass of XOR trees.
// Reset: synchronous, active low; clears both valid flags, payload is kept.
// ----------------------------------------------------------------------------
module gf2_163_field_multiplier
    import gf163_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_word i_a_word0,
    input  t_word i_a_word1,
    input  t_top  i_a_word2,
    input  t_word i_b_word0,
    input  t_word i_b_word1,
    input  t_top  i_b_word2,
    output logic  o_valid,
    input  logic  i_stall,
    output t_word o_prod_word0,
    output t_word o_prod_word1,
    output t_top  o_prod_word2
);

    logic  r_s1_valid;
    logic  n_s1_valid;
    t_elem r_a;
    t_elem r_b;
    logic  r_out_valid;
    logic  n_out_valid;
    t_elem r_prod;
    t_elem w_prod;
    logic  w_out_ld;
    logic  w_s1_ld;

    assign w_out_ld = !r_out_valid || !i_stall;
    assign w_s1_ld  = !r_s1_valid || w_out_ld;
    assign o_stall  = !w_s1_ld;

    assign n_s1_valid  = w_s1_ld ? i_valid : r_s1_valid;
    assign n_out_valid = w_out_ld ? r_s1_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ld && i_valid) begin
            r_a <= {i_a_word2, i_a_word1, i_a_word0};
            r_b <= {i_b_word2, i_b_word1, i_b_word0};
        end
        if (w_out_ld && r_s1_valid) begin
            r_prod <= w_prod;
        end
    end

    gf163_mul_core u_core (
        .i_a    (r_a),
        .i_b    (r_b),
        .o_prod (w_prod)
    );

    assign o_valid      = r_out_valid;
    assign o_prod_word0 = r_prod[WORD_W-1:0];
    assign o_prod_word1 = r_prod[2*WORD_W-1:WORD_W];
    assign o_prod_word2 = r_prod[ELEM_W-1:2*WORD_W];

    a_accept_fills_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_valid)
        else $error("accepted word not held in operand stage");

    a_s1_moves_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_out_ld) |=> o_valid)
        else $error("operand stage did not reach output");

    a_stall_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled while pipeline has room");

    a_s1_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_ld) |=> (r_s1_valid && $stable(r_a) && $stable(r_b)))
        else $error("blocked operand stage changed");

    a_zero_operand : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_out_ld && (r_a == '0)) |=> (o_prod_word0 == '0 &&
        o_prod_word1 == '0 && o_prod_word2 == '0))
        else $error("zero operand gave nonzero product");

endmodule
